### src/tfd_pkg.sv
// tfd_pkg: types and constants shared by the TPKT deframer files.
// No dependencies.
`default_nettype none

package tfd_pkg;

  localparam logic [7:0]  TpktVersion    = 8'h03;
  localparam logic [7:0]  TpktReserved   = 8'h00;
  localparam logic [15:0] TpktHeaderLen  = 16'd4;
  localparam logic [15:0] MaxPayloadRst  = 16'd65531;
  localparam int unsigned CfgAddrWidth   = 3;
  localparam logic        RegMaxPayload  = 1'b0;

  typedef enum logic [1:0] {
    HDR_VER    = 2'd0,
    HDR_ZERO   = 2'd1,
    HDR_LEN_HI = 2'd2,
    HDR_LEN_LO = 2'd3
  } tfd_hdr_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_flag;
    logic        last_flag;
    logic [15:0] frame_length;
    logic        bad_length;
  } tfd_result_t;

endpackage

`default_nettype wire

### src/tfd_byte_if.sv
// tfd_byte_if: valid/ready channel that carries one received byte.
// No dependencies.
`default_nettype none

interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/tfd_result_if.sv
// tfd_result_if: valid/ready channel that carries one deframer result.
// No dependencies.
`default_nettype none

interface tfd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_flag;
  logic        last_flag;
  logic [15:0] frame_length;
  logic        bad_length;

  modport source (output valid, output payload_byte, output first_flag, output last_flag,
                  output frame_length, output bad_length, input ready);
  modport sink   (input valid, input payload_byte, input first_flag, input last_flag,
                  input frame_length, input bad_length, output ready);
endinterface

`default_nettype wire

### src/tfd_apb_regs.sv
// tfd_apb_regs: APB register file holding max_payload.
// Depends on tfd_pkg.
`default_nettype none

module tfd_apb_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tfd_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  output logic [15:0]                           max_payload_o
);
  import tfd_pkg::*;

  logic [15:0] max_payload_q, max_payload_d;
  logic        wr_en;
  logic        sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[CfgAddrWidth-1] == RegMaxPayload);
  assign wr_en   = psel && penable && pwrite && sel_max;

  always_comb begin
    max_payload_d = max_payload_q;
    if (wr_en) begin
      max_payload_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
    end else begin
      max_payload_q <= max_payload_d;
    end
  end

  assign prdata        = sel_max ? {16'd0, max_payload_q} : 32'd0;
  assign max_payload_o = max_payload_q;

endmodule

`default_nettype wire

### src/tfd_parser.sv
// tfd_parser: input byte register, TPKT header/payload state and result forming.
// Depends on tfd_pkg.
`default_nettype none

module tfd_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           in_byte_i,
  input  wire logic [15:0]          max_payload_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output tfd_pkg::tfd_result_t      res_o
);
  import tfd_pkg::*;

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        fire;

  tfd_hdr_e    step_q, step_d;
  logic        in_payload_q, in_payload_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] total_len_q, total_len_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        seen_first_q, seen_first_d;

  logic [15:0] hdr_len;
  logic [15:0] pay_len;
  logic        len_bad;
  logic [15:0] left_dec;

  assign fire       = in_v_q && res_ready_i;
  assign in_ready_o = !in_v_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  assign hdr_len  = {len_hi_q, in_byte_q};
  assign pay_len  = hdr_len - TpktHeaderLen;
  assign len_bad  = (hdr_len <= TpktHeaderLen) || (pay_len > max_payload_i);
  assign left_dec = bytes_left_q - 16'd1;

  // next state
  always_comb begin
    step_d       = step_q;
    in_payload_d = in_payload_q;
    len_hi_d     = len_hi_q;
    total_len_d  = total_len_q;
    bytes_left_d = bytes_left_q;
    seen_first_d = seen_first_q;
    if (fire) begin
      if (!in_payload_q) begin
        case (step_q)
          HDR_VER:    step_d = (in_byte_q == TpktVersion) ? HDR_ZERO : HDR_VER;
          HDR_ZERO:   step_d = (in_byte_q == TpktReserved) ? HDR_LEN_HI : HDR_VER;
          HDR_LEN_HI: begin
            len_hi_d = in_byte_q;
            step_d   = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            step_d = HDR_VER;
            if (len_bad) begin
              total_len_d  = '0;
              bytes_left_d = '0;
              seen_first_d = 1'b0;
            end else begin
              total_len_d  = hdr_len;
              bytes_left_d = pay_len;
              seen_first_d = 1'b0;
              in_payload_d = 1'b1;
            end
          end
          default:    step_d = HDR_VER;
        endcase
      end else if ((bytes_left_q == '0) || (left_dec == '0)) begin
        step_d       = HDR_VER;
        in_payload_d = 1'b0;
        bytes_left_d = '0;
        total_len_d  = '0;
        seen_first_d = 1'b0;
      end else begin
        bytes_left_d = left_dec;
        seen_first_d = 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire) begin
      if (!in_payload_q) begin
        if ((step_q == HDR_LEN_LO) && len_bad) begin
          res_valid_o        = 1'b1;
          res_o.frame_length = hdr_len;
          res_o.bad_length   = 1'b1;
        end
      end else if (bytes_left_q != '0) begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = in_byte_q;
        res_o.first_flag   = !seen_first_q;
        res_o.last_flag    = (left_dec == '0);
        res_o.frame_length = total_len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= HDR_VER;
      in_payload_q <= 1'b0;
      len_hi_q     <= '0;
      total_len_q  <= '0;
      bytes_left_q <= '0;
      seen_first_q <= 1'b0;
    end else begin
      step_q       <= step_d;
      in_payload_q <= in_payload_d;
      len_hi_q     <= len_hi_d;
      total_len_q  <= total_len_d;
      bytes_left_q <= bytes_left_d;
      seen_first_q <= seen_first_d;
    end
  end

`ifndef ASSERT_OFF
  a_payload_hdr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (step_q == HDR_VER))
    else $error("header step moved during payload");
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_payload_q) |-> (bytes_left_q != '0) && !seen_first_q)
    else $error("payload entered with empty count");
  a_bad_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_length) |->
      (res_o.payload_byte == '0) && !res_o.first_flag && !res_o.last_flag)
    else $error("error result carries payload fields");
`endif

endmodule

`default_nettype wire

### src/tfd_out_buf.sv
// tfd_out_buf: result register with a skid stage between parser and output channel.
// Depends on tfd_pkg.
`default_nettype none

module tfd_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire tfd_pkg::tfd_result_t push_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tfd_pkg::tfd_result_t      out_data_o
);
  import tfd_pkg::*;

  logic        out_v_q, skid_v_q;
  tfd_result_t out_q, skid_q;
  logic        push, pop;

  assign push_ready_o = !skid_v_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push) begin
      skid_q <= push_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry without output entry");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i && push) |=> skid_v_q)
    else $error("stalled push not captured in skid");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_ready_i) |=> out_v_q && !skid_v_q)
    else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

### src/tpkt_frame_deframer.sv
// TPKT frame deframer top level: byte input channel, result output channel, APB register.
// Instantiates tfd_apb_regs, tfd_parser and tfd_out_buf; uses tfd_pkg and the channel interfaces.
//
// Usage:
//   rx_i takes one stream byte per transaction. res_o gives one transaction per payload
//   byte (payload_byte, first_flag, last_flag, frame_length) or one error transaction
//   (bad_length = 1) when a header length is at most 4 or gives a payload above max_payload.
//   Header bytes and dropped frames give no transaction.
//   Throughput: one byte per clock while the output buffer accepts results, set by the parser state update.
//   Each result passes the input register, then the result register, before it is valid on
//   res_o; it can be taken at the following edge at the earliest.
//   max_payload lies at APB address 0; write it only while the block is idle.
//   Reset clears the parser to the header search, empties both output entries and
//   sets max_payload to 65531.
//   When res_o stalls, a skid entry keeps one more result and rx_i stays ready
//   until both the skid entry and the input register are full.
`default_nettype none

module tpkt_frame_deframer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tfd_byte_if.sink                              rx_i,
  tfd_result_if.source                          res_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tfd_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import tfd_pkg::*;

  logic [15:0] max_payload;
  logic        res_valid, res_ready;
  tfd_result_t res_data, out_data;

  tfd_apb_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .max_payload_o (max_payload)
  );

  tfd_parser u_parser (
    .clk_i,
    .rst_ni,
    .in_valid_i    (rx_i.valid),
    .in_ready_o    (rx_i.ready),
    .in_byte_i     (rx_i.rx_byte),
    .max_payload_i (max_payload),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res_data)
  );

  tfd_out_buf u_out (
    .clk_i,
    .rst_ni,
    .push_valid_i (res_valid),
    .push_ready_o (res_ready),
    .push_data_i  (res_data),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .out_data_o   (out_data)
  );

  assign res_o.payload_byte = out_data.payload_byte;
  assign res_o.first_flag   = out_data.first_flag;
  assign res_o.last_flag    = out_data.last_flag;
  assign res_o.frame_length = out_data.frame_length;
  assign res_o.bad_length   = out_data.bad_length;

endmodule

`default_nettype wire

### verif/tpkt_frame_deframer_tb.sv
// tpkt_frame_deframer_tb: self-checking testbench for the TPKT deframer; random byte streams,
// APB writes of max_payload, an in-order prediction of every result transaction.
// Depends on tfd_pkg, tfd_byte_if, tfd_result_if and tpkt_frame_deframer.
`default_nettype none

module tpkt_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  localparam logic [CfgAddrWidth-1:0] MaxPayloadAddr = {RegMaxPayload, 2'b00};
  localparam logic [CfgAddrWidth-1:0] UnusedAddr     = 3'd4;
  localparam int unsigned             DrainCycles    = 12;
  localparam int unsigned             LongStall      = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tfd_byte_if   rx_if ();
  tfd_result_if res_if ();

  tpkt_frame_deframer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // stream bytes waiting to be sent, result transactions waiting to arrive
  logic [7:0]  byte_q[$];
  tfd_result_t frame_res_q[$];

  int unsigned err_cnt = 0;
  logic        idle_on = 1'b1;
  logic        rx_hold = 1'b0;
  logic        res_hold = 1'b0;
  int unsigned rx_gap;
  int unsigned res_gap;
  tfd_result_t res_want;

  // deframer state mirror
  logic [15:0] cfg_max = MaxPayloadRst;
  tfd_hdr_e    hdr_step = HDR_VER;
  logic        in_payload = 1'b0;
  logic [7:0]  len_hi = '0;
  logic [15:0] tot_len = '0;
  logic [15:0] bytes_left = '0;
  logic        seen_first = 1'b0;

  function automatic void append_byte(logic [7:0] b);
    byte_q = {byte_q, b};
  endfunction

  function automatic void expect_result(tfd_result_t r);
    frame_res_q = {frame_res_q, r};
  endfunction

  function automatic void restart_header();
    hdr_step   = HDR_VER;
    in_payload = 1'b0;
    bytes_left = '0;
    tot_len    = '0;
    seen_first = 1'b0;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    tfd_result_t r;
    logic [15:0] len;
    r = '0;
    if (!in_payload) begin
      case (hdr_step)
        HDR_VER: begin
          if (b == TpktVersion) hdr_step = HDR_ZERO;
        end
        HDR_ZERO: begin
          hdr_step = (b == TpktReserved) ? HDR_LEN_HI : HDR_VER;
        end
        HDR_LEN_HI: begin
          len_hi   = b;
          hdr_step = HDR_LEN_LO;
        end
        default: begin
          len      = {len_hi, b};
          hdr_step = HDR_VER;
          if (len <= TpktHeaderLen || len - TpktHeaderLen > cfg_max) begin
            restart_header();
            r.frame_length = len;
            r.bad_length   = 1'b1;
            expect_result(r);
          end else begin
            tot_len    = len;
            bytes_left = len - TpktHeaderLen;
            seen_first = 1'b0;
            in_payload = 1'b1;
          end
        end
      endcase
    end else if (bytes_left == 0) begin
      restart_header();
    end else begin
      r.payload_byte = b;
      r.first_flag   = !seen_first;
      bytes_left     = bytes_left - 16'd1;
      r.last_flag    = (bytes_left == 0);
      r.frame_length = tot_len;
      seen_first     = 1'b1;
      if (bytes_left == 0) restart_header();
      expect_result(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      rx_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) deframe_byte(byte_q.pop_front());
      if (rx_if.valid && !rx_if.ready) begin
        // hold the offered transaction
      end else if (rx_gap > 0) begin
        rx_gap--;
        rx_if.valid <= 1'b0;
      end else if (byte_q.size() > 0 && !rx_hold && idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 17);
        rx_if.valid <= 1'b0;
      end else if (byte_q.size() > 0 && !rx_hold) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_q[0];
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (frame_res_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          res_want = frame_res_q.pop_front();
          if (res_if.payload_byte !== res_want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h",
                                      res_if.payload_byte, res_want.payload_byte));
          if (res_if.first_flag !== res_want.first_flag)
            report_mismatch($sformatf("first_flag %b, want %b",
                                      res_if.first_flag, res_want.first_flag));
          if (res_if.last_flag !== res_want.last_flag)
            report_mismatch($sformatf("last_flag %b, want %b",
                                      res_if.last_flag, res_want.last_flag));
          if (res_if.frame_length !== res_want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      res_if.frame_length, res_want.frame_length));
          if (res_if.bad_length !== res_want.bad_length)
            report_mismatch($sformatf("bad_length %b, want %b",
                                      res_if.bad_length, res_want.bad_length));
        end
      end
      if (res_hold) begin
        res_if.ready <= 1'b0;
      end else if (res_gap > 0) begin
        res_gap--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_gap = $urandom_range(0, 17);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [CfgAddrWidth-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MaxPayloadAddr) cfg_max = data[15:0];
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || frame_res_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_header(int unsigned len);
    append_byte(TpktVersion);
    append_byte(TpktReserved);
    append_byte(len[15:8]);
    append_byte(len[7:0]);
  endtask

  task automatic push_frame(int unsigned pay_len);
    push_header(pay_len + TpktHeaderLen);
    repeat (pay_len) append_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed frames, the rest short or long lengths, noise and broken headers
  task automatic gen_stream(int unsigned n);
    int unsigned cnt;
    int unsigned kind;
    int unsigned hi;
    int unsigned p;
    int unsigned k;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        hi = (cfg_max < 24) ? cfg_max : 24;
        if ($urandom_range(0, 39) == 0) hi = (cfg_max < 300) ? cfg_max : 300;
        p = (hi == 0) ? $urandom_range(1, 3) : $urandom_range(1, hi);
        push_frame(p);
        cnt += p + TpktHeaderLen;
      end else if (kind == 6) begin
        push_header($urandom_range(0, 4));
        cnt += TpktHeaderLen;
      end else if (kind == 7) begin
        if (int'(cfg_max) + 5 <= 65535) push_header($urandom_range(int'(cfg_max) + 5, 65535));
        else push_header($urandom_range(0, 4));
        cnt += TpktHeaderLen;
      end else if (kind == 8) begin
        k = $urandom_range(1, 4);
        repeat (k) append_byte(8'($urandom_range(0, 255)));
        cnt += k;
      end else begin
        append_byte(TpktVersion);
        append_byte(8'($urandom_range(1, 255)));
        cnt += 2;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset max_payload: one-byte frame, short lengths, header mismatches
    push_frame(1);
    push_header(4);
    push_header(0);
    append_byte(8'h07);
    append_byte(TpktVersion);
    append_byte(8'h01);
    append_byte(TpktVersion);
    append_byte(TpktVersion);
    append_byte(TpktReserved);
    push_header(6);
    append_byte(8'h00);
    append_byte(8'hff);
    wait_idle();

    // write to an unused address leaves max_payload alone
    reg_write(UnusedAddr, 32'h0000_0000);
    gen_stream(200);
    wait_idle();

    // zero max_payload rejects every frame
    reg_write(MaxPayloadAddr, 32'd0);
    push_frame(1);
    gen_stream(150);
    wait_idle();

    reg_write(MaxPayloadAddr, 32'd1);
    gen_stream(150);
    wait_idle();

    // small limit: exact fit, one over, largest header length; then backpressure
    reg_write(MaxPayloadAddr, 32'd20);
    push_frame(20);
    push_header(25);
    push_header(16'hffff);
    gen_stream(300);
    @(posedge clk_i);
    res_hold <= 1'b1;
    repeat (LongStall) @(posedge clk_i);
    res_hold <= 1'b0;
    while (byte_q.size() > 120) @(posedge clk_i);
    rx_hold <= 1'b1;
    while (frame_res_q.size() != 0) @(posedge clk_i);
    rx_hold <= 1'b0;
    wait_idle();

    reg_write(MaxPayloadAddr, 32'hffff_ffff);
    gen_stream(200);
    wait_idle();

    // back-to-back transactions, no idling
    reg_write(MaxPayloadAddr, {16'h0000, MaxPayloadRst});
    idle_on <= 1'b0;
    gen_stream(200);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tpkt_frame_deframer test passed");
    end else begin
      $display("tpkt_frame_deframer test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d result transactions outstanding", frame_res_q.size());
    $display("tpkt_frame_deframer test failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/tfd_pkg.sv
src/tfd_byte_if.sv
src/tfd_result_if.sv
src/tfd_apb_regs.sv
src/tfd_parser.sv
src/tfd_out_buf.sv
src/tpkt_frame_deframer.sv
verif/tpkt_frame_deframer_tb.sv
